// ===== sv/thread_key_value_hash_table_top_macros.svh =====
// Assertion macros for the key/value table.
`ifndef THREAD_KEY_VALUE_HASH_TABLE_TOP_MACROS_SVH
`define THREAD_KEY_VALUE_HASH_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/tkv_pkg.sv =====
`default_nettype none
package tkv_pkg;
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_SET = 3'd1;
  localparam logic [2:0] OP_GET = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_DESTROY_ALL = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_CHECK, S_RESULT
  } state_t;
endpackage
`default_nettype wire

// ===== sv/thread_key_value_hash_table_top.sv =====
// Per-thread key/value table, set-associative with WAYS entries per bucket.
// The request channel (valid, ready) carries opcode, thread_id, key, value.
// The result channel (out_valid, out_ready) carries status, key_out,
// value_out; exactly one result follows each request.
// Ready is high only when the sequencer is idle and no result is held.
// Entries live in one single-port-read memory that is swept one way at a time.
// Create key goes straight to the result; set/get/destroy check the bucket's
// ways in turn until a match, and destroy all does so for every issued key.
// After reset a clearing pass writes every entry invalid, one per cycle,
// before the first request is taken. A stalled receiver holds the result
// in the output register and the block takes no new request until it is
// delivered.
`default_nettype none
`include "thread_key_value_hash_table_top_macros.svh"
module thread_key_value_hash_table_top import tkv_pkg::*; #(
  parameter int BUCKETS = 512,
  parameter int WAYS = 4,
  parameter int TID_WIDTH = 16,
  parameter int KEY_WIDTH = 10,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   valid,
  output logic                        ready,
  input  wire logic [2:0]             opcode,
  input  wire logic [TID_WIDTH-1:0]   thread_id,
  input  wire logic [KEY_WIDTH-1:0]   key,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [KEY_WIDTH-1:0]        key_out,
  output logic [VALUE_WIDTH-1:0]      value_out
);
  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT = BUCKETS * WAYS;
  localparam int AW = $clog2(ENT);
  localparam int DW = 1 + TID_WIDTH + KEY_WIDTH + VALUE_WIDTH;
  localparam int CW = AW + 1;

  state_t state, state_next;
  logic [2:0] op;
  logic [TID_WIDTH-1:0] tid;
  logic [KEY_WIDTH-1:0] k;
  logic [VALUE_WIDTH-1:0] val;
  logic [KEY_WIDTH:0] next_key;
  logic [WW-1:0] way;
  logic [CW-1:0] clr;
  logic hit, free_seen, miss_any;
  logic [WW-1:0] free_way;
  logic [BW-1:0] bucket;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic rd_v;
  logic [TID_WIDTH-1:0] rd_t;
  logic [KEY_WIDTH-1:0] rd_k;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic match, last_way;

  // Bucket arithmetic: only the low BW bits of key + tid*16 matter
  // when BUCKETS is a power of two; otherwise a mod by constant.
  logic [KEY_WIDTH+TID_WIDTH+4:0] bsum;
  assign bsum = {{(TID_WIDTH+5){1'b0}}, k} + {{(KEY_WIDTH+1){1'b0}}, tid, 4'b0000};
  assign bucket = BW'(bsum % BUCKETS);

  assign {rd_v, rd_t, rd_k, rd_val} = rdata;
  assign match = rd_v && rd_t == tid && rd_k == k;
  assign last_way = (WAYS == 1) || (way == WW'(WAYS - 1));
  assign raddr = AW'(bucket) * AW'(WAYS) + AW'(way);

  tkv_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      next_key <= (KEY_WIDTH+1)'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (valid && ready) begin
        op <= opcode; tid <= thread_id; val <= value;
        way <= '0;
        hit <= 1'b0; free_seen <= 1'b0; miss_any <= 1'b0;
        k <= (opcode == OP_DESTROY_ALL) ? KEY_WIDTH'(1) : key;
      end
      if (state == S_CHECK) begin
        if (match && !hit) hit <= 1'b1;
        if (!rd_v && !free_seen) begin free_seen <= 1'b1; free_way <= way; end
        if (!last_way && !match) way <= way + 1'b1;
      end
      if (state == S_RESULT) begin
        out_valid <= 1'b1;
        key_out <= '0; value_out <= '0; status <= ST_OK;
        case (op)
          OP_CREATE: begin
            if (next_key > (KEY_WIDTH+1)'({KEY_WIDTH{1'b1}})) status <= ST_FULL;
            else begin
              key_out <= next_key[KEY_WIDTH-1:0];
              next_key <= next_key + 1'b1;
            end
          end
          OP_SET: if (!hit && !free_seen) status <= ST_FULL;
          OP_GET: if (hit) value_out <= rd_val; else status <= ST_MISS;
          OP_DESTROY: if (!hit) status <= ST_MISS;
          OP_DESTROY_ALL: if (miss_any) status <= ST_MISS;
          default: ;
        endcase
      end
      // Destroy all: after each key, move to the next one.
      if (state == S_WAIT && op == OP_DESTROY_ALL) begin
        if (!hit) miss_any <= 1'b1;
        k <= k + 1'b1; way <= '0; hit <= 1'b0;
      end
    end
  end

  // Sequencer: READ issues address, CHECK looks at the returned way.
  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = AW'(bucket) * AW'(WAYS) + AW'(way);
    wdata = {1'b1, tid, k, val};
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr[AW-1:0];
        wdata = '0;
        if (clr == CW'(ENT - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (valid && ready) begin
        if (opcode == OP_SET || opcode == OP_GET || opcode == OP_DESTROY)
          state_next = S_READ;
        else if (opcode == OP_DESTROY_ALL)
          state_next = (next_key > (KEY_WIDTH+1)'(1)) ? S_READ : S_RESULT;
        else state_next = S_RESULT;
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (match || last_way) begin
          if (op == OP_GET && match) state_next = S_RESULT;
          else state_next = S_WAIT;
          if (match && (op == OP_DESTROY || op == OP_DESTROY_ALL)) begin
            we = 1'b1; wdata = '0;
          end else if (match && op == OP_SET) begin
            we = 1'b1;
          end
        end else state_next = S_READ;
      end
      S_WAIT: begin
        // Write free way on a set miss; way register holds last way.
        if (op == OP_SET && !hit && free_seen) begin
          we = 1'b1;
          waddr = AW'(bucket) * AW'(WAYS) + AW'(free_way);
        end
        if (op == OP_DESTROY_ALL &&
            (KEY_WIDTH+1)'(k) + 1'b1 < next_key) state_next = S_READ;
        else state_next = S_RESULT;
      end
      S_RESULT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // GET miss reaches RESULT via WAIT; a hit comes directly so rdata still holds.
  `ASSERT_IMPL(a_ready_idle, clk, rst, ready |-> state == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_result, clk, rst, state == S_RESULT, out_valid, "result not shown")
  `ASSERT_NEXT(a_accept, clk, rst, valid && ready, !ready, "ready after accept")
endmodule
`default_nettype wire

// ===== sv/tkv_ram.sv =====
`default_nettype none
module tkv_ram #(
  parameter int AW = 11,
  parameter int DW = 59
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
